// ===== hdl/rdd_pkg.sv =====
// rdd_pkg: shared types, constants and the CORDIC arctangent table for the
// rotation direction detector. No dependencies.
package rdd_pkg;

  localparam int unsigned WindowPointsDef = 30;
  localparam int unsigned DeltaPairsDef   = 28;
  localparam int unsigned CordicSteps     = 18;
  localparam int unsigned StepW           = 5;
  localparam int unsigned CoordW          = 16;
  localparam int unsigned PointW          = 32;
  localparam int unsigned SumW            = 19;
  localparam int unsigned AngleW          = 16;
  // CORDIC vector components: 17-bit difference shifted by 12, plus growth
  localparam int unsigned VecW            = 32;
  localparam int unsigned AccW            = 32;
  localparam int unsigned QuarterPi       = 8192;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_CCW     = 2'd1,
    DIR_CW      = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_CORDIC,
    ST_ACCUM,
    ST_DECIDE,
    ST_WRITE,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch input word
    logic rd_en;       // issue store read
    logic cordic_load; // load CORDIC from read data
    logic cordic_step; // one CORDIC iteration
    logic accum;       // fold finished angle into sum
    logic clear_sum;   // start a new sum
    logic decide;      // saturate, update last_sum and direction
    logic wr_en;       // append input point
    logic force_dir;   // apply force item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode;
    logic dir_known;
    logic enough;      // enough points stored for a decision
  } stat_t;

  function automatic logic [AccW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic [AccW-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/rdd_ram.sv =====
// rdd_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module rdd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rdd_ctrl.sv =====
// rdd_ctrl: sequencer for the rotation direction detector. Walks the stored
// points newest to oldest, one CORDIC at a time. Depends on rdd_pkg.
module rdd_ctrl import rdd_pkg::*; #(
  parameter int unsigned DeltaPairs = DeltaPairsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_fire_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  first_o,      // current angle is the newest point
  output logic [$clog2(DeltaPairs+1)-1:0] age_o,
  output logic  in_ready_o,
  output logic  out_valid_o
);

  localparam int unsigned AgeW = $clog2(DeltaPairs + 1);

  state_e           state_q, state_d;
  logic [AgeW-1:0]  age_q, age_d;
  logic [StepW-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      age_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      age_q   <= age_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    age_d       = age_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (stat_i.mode) begin
          cmd_o.force_dir = 1'b1;
          state_d = ST_OUT;
        end else if (stat_i.dir_known) begin
          state_d = ST_OUT;
        end else if (!stat_i.enough) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.clear_sum = 1'b1;
          age_d   = '0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd_o.cordic_load = 1'b1;
        iter_d  = '0;
        state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == StepW'(CordicSteps - 1)) state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (age_q == AgeW'(DeltaPairs)) begin
          state_d = ST_DECIDE;
        end else begin
          age_d       = age_q + 1'b1;
          cmd_o.rd_en = 1'b1;
          state_d     = ST_WAIT;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_fire_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign first_o = (age_q == '0);
  assign age_o   = age_d;

`ifndef SYNTHESIS
  a_age_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_q <= AgeW'(DeltaPairs)) else $error("age past pair count");
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= StepW'(CordicSteps)) else $error("CORDIC iteration overrun");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accept while result pending");
`endif

endmodule

// ===== hdl/rdd_dp.sv =====
// rdd_dp: datapath of the rotation direction detector: point window, CORDIC
// atan2 unit, angle difference sum and direction register. Depends on rdd_pkg,
// rdd_ram.
module rdd_dp import rdd_pkg::*; #(
  parameter int unsigned WindowPoints = WindowPointsDef,
  parameter int unsigned DeltaPairs   = DeltaPairsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                first_i,
  input  logic [$clog2(DeltaPairs+1)-1:0] age_i,
  input  logic                mode_i,
  input  logic [CoordW-1:0]   point_x_i,
  input  logic [CoordW-1:0]   point_y_i,
  input  logic [CoordW-1:0]   center_x_i,
  input  logic [CoordW-1:0]   center_y_i,
  input  logic                force_cw_i,
  output stat_t               stat_o,
  output logic [1:0]          direction_code_o,
  output logic signed [SumW-1:0] angle_sum_o
);

  localparam int unsigned SlotW = $clog2(WindowPoints);
  localparam int unsigned CntW  = $clog2(WindowPoints + 1);
  // wide enough for DeltaPairs * 8192 plus sign
  localparam int unsigned AccSW = SumW + 8;

  // latched item
  logic                mode_q, force_cw_q;
  logic [PointW-1:0]   point_q;
  logic [CoordW-1:0]   cx_q, cy_q;

  logic [CntW-1:0]     count_q;
  logic [SlotW-1:0]    oldest_q;
  dir_e                dir_q;
  logic signed [SumW-1:0] last_sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_i;
      force_cw_q <= force_cw_i;
      point_q    <= {point_y_i, point_x_i};
      cx_q       <= center_x_i;
      cy_q       <= center_y_i;
    end
  end

  // slot address: (oldest + idx) mod WindowPoints, idx < WindowPoints
  function automatic logic [SlotW-1:0] slot_of(input logic [SlotW-1:0] base,
                                               input logic [CntW-1:0] idx);
    logic [CntW:0] s;
    s = (CntW+1)'(base) + (CntW+1)'(idx);
    if (s >= (CntW+1)'(WindowPoints)) s = s - (CntW+1)'(WindowPoints);
    return s[SlotW-1:0];
  endfunction

  logic [CntW-1:0]  rd_idx;
  logic [SlotW-1:0] raddr, waddr;
  logic [PointW-1:0] rdata;

  assign rd_idx = count_q - 1'b1 - CntW'(age_i);
  assign raddr  = slot_of(oldest_q, rd_idx);
  assign waddr  = (count_q < CntW'(WindowPoints)) ? slot_of(oldest_q, count_q) : oldest_q;

  rdd_ram #(.Width(PointW), .Depth(WindowPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (point_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // CORDIC
  logic signed [VecW-1:0] x_q, y_q, x_d, y_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [StepW-1:0]       it_q;
  logic                   zero_q;
  logic signed [CoordW:0] dx, dy;
  logic signed [VecW-1:0] x0, y0;

  assign dx = $signed({1'b0, rdata[CoordW-1:0]}) - $signed({1'b0, cx_q});
  assign dy = $signed({1'b0, rdata[PointW-1:CoordW]}) - $signed({1'b0, cy_q});
  assign x0 = VecW'(dx) <<< 12;
  assign y0 = -(VecW'(dy) <<< 12);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    acc_d = acc_q;
    if (cmd_i.cordic_load) begin
      if (dx < 0) begin
        x_d   = -x0;
        y_d   = -y0;
        acc_d = 32'h8000_0000;
      end else begin
        x_d   = x0;
        y_d   = y0;
        acc_d = '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (y_q >= 0) begin
        x_d   = x_q + (y_q >>> it_q);
        y_d   = y_q - (x_q >>> it_q);
        acc_d = acc_q + atan_lut(it_q);
      end else begin
        x_d   = x_q - (y_q >>> it_q);
        y_d   = y_q + (x_q >>> it_q);
        acc_d = acc_q - atan_lut(it_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.cordic_load) begin
      it_q <= '0;
    end else if (cmd_i.cordic_step) begin
      it_q <= it_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    if (cmd_i.cordic_load) zero_q <= (dx == 0) && (dy == 0);
  end

  logic [AccW-1:0]   acc_fin;
  logic [AngleW-1:0] angle;
  assign acc_fin = acc_q + 32'h8000_0000 + 32'h0000_8000;
  assign angle   = zero_q ? AngleW'(32768) : acc_fin[AccW-1:AccW-AngleW];

  // difference sum
  logic [AngleW-1:0]       newer_q;
  logic signed [AccSW-1:0] sum_q;
  logic signed [AngleW:0]  diff;

  assign diff = $signed({1'b0, newer_q}) - $signed({1'b0, angle});

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_sum) sum_q <= '0;
    else if (cmd_i.accum) begin
      newer_q <= angle;
      if (!first_i && diff <= $signed((AngleW+1)'(QuarterPi)) &&
          diff >= -$signed((AngleW+1)'(QuarterPi)))
        sum_q <= sum_q + AccSW'(diff);
    end
  end

  logic signed [SumW-1:0] sat;
  always_comb begin
    if (sum_q > AccSW'((1 << (SumW-1)) - 1))       sat = {1'b0, {(SumW-1){1'b1}}};
    else if (sum_q < -AccSW'(1 << (SumW-1)))      sat = {1'b1, {(SumW-1){1'b0}}};
    else                                         sat = sum_q[SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      oldest_q   <= '0;
      dir_q      <= DIR_UNKNOWN;
      last_sum_q <= '0;
    end else begin
      if (cmd_i.force_dir) dir_q <= force_cw_q ? DIR_CW : DIR_CCW;
      if (cmd_i.decide) begin
        last_sum_q <= sat;
        if (sat > 0)      dir_q <= DIR_CCW;
        else if (sat < 0) dir_q <= DIR_CW;
        else              dir_q <= DIR_UNKNOWN;
      end
      if (cmd_i.wr_en) begin
        if (count_q < CntW'(WindowPoints)) begin
          count_q <= count_q + 1'b1;
        end else if (oldest_q == SlotW'(WindowPoints - 1)) begin
          oldest_q <= '0;
        end else begin
          oldest_q <= oldest_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.mode      = mode_q;
  assign stat_o.dir_known = (dir_q != DIR_UNKNOWN);
  assign stat_o.enough    = (DeltaPairs + 1 <= WindowPoints) &&
                            (count_q >= CntW'(DeltaPairs + 1));
  assign direction_code_o = dir_q;
  assign angle_sum_o      = last_sum_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(WindowPoints)) else $error("point count overflow");
  a_oldest_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < CntW'(WindowPoints)) |-> (oldest_q == '0))
    else $error("window rotated before full");
  a_force_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.force_dir |=> (dir_q != DIR_UNKNOWN)) else $error("force lost");
`endif

endmodule

// ===== hdl/rotation_direction_detector_unit.sv =====
// Rotation direction detector: each sample item gives one result word.
// A force item or a known direction goes straight to the output; a sample below the point
// threshold is only stored; a decision runs the one shared CORDIC unit over DeltaPairs+1
// stored angles, with one store read per angle. One item at a time; the next word is taken
// the cycle after the result leaves. rst_ni clears count, window position, direction, sum.
module rotation_direction_detector_unit import rdd_pkg::*; #(
  parameter int unsigned WindowPoints = WindowPointsDef,
  parameter int unsigned DeltaPairs   = DeltaPairsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x[15:0], point_y[31:16], center_x[47:32], center_y[63:48],
  // force_cw[64], zero pad
  input  logic [71:0] s_axis_tdata,
  // mode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // direction_code[1:0], angle_sum[20:2], zero pad
  output logic [23:0] m_axis_tdata
);

  cmd_t  cmd;
  stat_t stat;
  logic  first;
  logic [$clog2(DeltaPairs+1)-1:0] age;
  logic [1:0] dir_code;
  logic signed [SumW-1:0] angle_sum;

  rdd_ctrl #(.DeltaPairs(DeltaPairs)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .out_fire_i  (m_axis_tvalid && m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .first_o     (first),
    .age_o       (age),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  rdd_dp #(.WindowPoints(WindowPoints), .DeltaPairs(DeltaPairs)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .first_i          (first),
    .age_i            (age),
    .mode_i           (s_axis_tuser),
    .point_x_i        (s_axis_tdata[15:0]),
    .point_y_i        (s_axis_tdata[31:16]),
    .center_x_i       (s_axis_tdata[47:32]),
    .center_y_i       (s_axis_tdata[63:48]),
    .force_cw_i       (s_axis_tdata[64]),
    .stat_o           (stat),
    .direction_code_o (dir_code),
    .angle_sum_o      (angle_sum)
  );

  assign m_axis_tdata = {3'b000, angle_sum, dir_code};

endmodule
